// ===== hw/rtl/cia_pkg.sv =====
// Shared types and constants of the checked integer ALU.
package cia_pkg;

  localparam int unsigned MaxWidth         = 64;
  localparam int unsigned DataWidthDefault = 64;
  localparam int unsigned FifoDepthDefault = 4;

  typedef enum logic [3:0] {
    OP_OR   = 4'd0,
    OP_XOR  = 4'd1,
    OP_AND  = 4'd2,
    OP_ADD  = 4'd3,
    OP_SUB  = 4'd4,
    OP_MUL  = 4'd5,
    OP_DIV  = 4'd6,
    OP_MOD  = 4'd7,
    OP_SHR  = 4'd8,
    OP_SHL  = 4'd9,
    OP_NEG  = 4'd10,
    OP_PLUS = 4'd11,
    OP_NOT  = 4'd12
  } op_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_OVF     = 3'd1,
    ST_DIV0    = 3'd2,
    ST_SHIFT   = 3'd3,
    ST_INVALID = 3'd4,
    ST_NOVALUE = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_BUSY,
    DIV_DONE
  } div_state_e;

  typedef struct packed {
    op_e                 op;
    logic                sg;
    status_e             st;
    logic [MaxWidth-1:0] a;
    logic [MaxWidth-1:0] b;
  } cmd_t;

endpackage

// ===== hw/rtl/cia_if.sv =====
// Handshake interfaces for the request and result channels of the ALU.
interface cia_in_if;
  import cia_pkg::*;
  logic                valid;
  logic                ready;
  logic [3:0]          kind;
  logic                sign_mode;
  logic                operands_present;
  logic [MaxWidth-1:0] left_operand;
  logic [MaxWidth-1:0] right_operand;

  modport source (output valid, kind, sign_mode, operands_present, left_operand,
                  right_operand, input ready);
  modport sink (input valid, kind, sign_mode, operands_present, left_operand,
                right_operand, output ready);
  modport monitor (input valid, ready, kind, sign_mode, operands_present, left_operand,
                   right_operand);
endinterface

interface cia_out_if;
  import cia_pkg::*;
  logic                valid;
  logic                ready;
  logic [MaxWidth-1:0] value;
  logic                value_is_signed;
  logic [2:0]          status;

  modport source (output valid, value, value_is_signed, status, input ready);
  modport sink (input valid, value, value_is_signed, status, output ready);
  modport monitor (input valid, ready, value, value_is_signed, status);
endinterface

// ===== hw/rtl/cia_front.sv =====
// Front end: accepts requests, masks operands and classifies the operation.
module cia_front #(
  parameter int unsigned DataWidth = cia_pkg::DataWidthDefault
) (
  cia_in_if.sink        in_i,
  input  logic          full_i,
  output logic          push_o,
  output cia_pkg::cmd_t cmd_o
);
  import cia_pkg::*;

  localparam logic [MaxWidth-1:0] Mask = {MaxWidth{1'b1}} >> (MaxWidth - DataWidth);

  always_comb begin
    cmd_o.sg = in_i.sign_mode;
    cmd_o.a  = in_i.left_operand & Mask;
    cmd_o.b  = in_i.right_operand & Mask;
    cmd_o.op = OP_OR;
    cmd_o.st = ST_OK;
    // A missing operand takes precedence over an unknown operation.
    priority if (!in_i.operands_present) begin
      cmd_o.st = ST_NOVALUE;
    end else if (in_i.kind > OP_NOT) begin
      cmd_o.st = ST_INVALID;
    end else begin
      cmd_o.op = op_e'(in_i.kind);
    end
  end

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;

endmodule

// ===== hw/rtl/cia_fifo.sv =====
// Short command queue that decouples the front end from the back end.
module cia_fifo #(
  parameter int unsigned Depth = cia_pkg::FifoDepthDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  cia_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output cia_pkg::cmd_t data_o
);
  import cia_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == (PtrW+1)'(Depth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + (PtrW+1)'(push_i) - (PtrW+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== hw/rtl/cia_div.sv =====
// Restoring divider on magnitudes, one quotient bit per cycle.
module cia_div #(
  parameter int unsigned DataWidth = cia_pkg::DataWidthDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DataWidth-1:0] dividend_i,
  input  logic [DataWidth-1:0] divisor_i,
  input  logic                 ack_i,
  output logic                 idle_o,
  output logic                 done_o,
  output logic [DataWidth-1:0] quo_o,
  output logic [DataWidth-1:0] rem_o
);
  import cia_pkg::*;

  localparam int unsigned W  = DataWidth;
  localparam int unsigned CW = $clog2(W);

  div_state_e     state_q, state_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic [W-1:0]   quo_q, rem_q, dvs_q;
  logic [W:0]     trial;
  logic           load, step;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    load    = 1'b0;
    step    = 1'b0;
    unique case (state_q)
      DIV_IDLE: begin
        if (start_i) begin
          load    = 1'b1;
          cnt_d   = '0;
          state_d = DIV_BUSY;
        end
      end
      DIV_BUSY: begin
        step  = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CW'(W - 1)) begin
          state_d = DIV_DONE;
        end
      end
      DIV_DONE: begin
        if (ack_i) begin
          state_d = DIV_IDLE;
        end
      end
      default: state_d = DIV_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIV_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign trial = {rem_q, quo_q[W-1]} - {1'b0, dvs_q};

  always_ff @(posedge clk_i) begin
    if (load) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (step) begin
      if (!trial[W]) begin
        rem_q <= trial[W-1:0];
        quo_q <= {quo_q[W-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[W-2:0], quo_q[W-1]};
        quo_q <= {quo_q[W-2:0], 1'b0};
      end
    end
  end

  assign idle_o = (state_q == DIV_IDLE);
  assign done_o = (state_q == DIV_DONE);
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

// ===== hw/rtl/cia_back.sv =====
// Back end: executes queued commands through a two-stage pipeline and result register.
module cia_back #(
  parameter int unsigned DataWidth = cia_pkg::DataWidthDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          head_valid_i,
  input  cia_pkg::cmd_t head_i,
  output logic          pop_o,
  cia_out_if.source     out_o
);
  import cia_pkg::*;

  localparam int unsigned W  = DataWidth;
  localparam int unsigned H  = (W + 1) / 2;
  localparam int unsigned PW = 4 * H;
  localparam int unsigned SW = $clog2(W);
  localparam logic [W-1:0] MinV  = W'(1) << (W - 1);
  localparam logic [W-1:0] MaxP  = MinV - 1'b1;
  localparam logic [W-1:0] WidthV = W'(W);

  logic [W-1:0]   a, b, mag_a, mag_b, quo, rem;
  logic           neg_a, neg_b, sg;
  logic [W:0]     sum, diff;
  logic [SW-1:0]  sh;
  logic           is_div, div_ovf, needs_div, div_idle, div_done;
  logic           a_valid, s2_free, out_free;

  // Stage A results.
  status_e        a_st;
  logic [W-1:0]   a_val;
  logic           a_vsg, a_mul, a_neg;
  logic [2*H-1:0] a_pp00, a_pp01, a_pp10, a_pp11;

  // Stage B registers.
  logic           s2_valid_q;
  status_e        s2_st_q;
  logic [W-1:0]   s2_val_q;
  logic           s2_vsg_q, s2_mul_q, s2_neg_q;
  logic [2*H-1:0] s2_pp00_q, s2_pp01_q, s2_pp10_q, s2_pp11_q;

  // Result register.
  logic           out_valid_q;
  status_e        out_st_q;
  logic [W-1:0]   out_val_q;
  logic           out_vsg_q;

  // Stage B combine.
  logic [PW-1:0]  prod;
  logic [W-1:0]   prod_lo;
  logic           prod_hi_nz, mul_ovf;
  status_e        c_st;
  logic [W-1:0]   c_val;

  assign a     = head_i.a[W-1:0];
  assign b     = head_i.b[W-1:0];
  assign sg    = head_i.sg;
  assign neg_a = sg & a[W-1];
  assign neg_b = sg & b[W-1];
  assign mag_a = neg_a ? {W{1'b0}} - a : a;
  assign mag_b = neg_b ? {W{1'b0}} - b : b;
  assign sum   = {1'b0, a} + {1'b0, b};
  assign diff  = {1'b0, a} - {1'b0, b};
  assign sh    = b[SW-1:0];

  assign is_div    = (head_i.op == OP_DIV) || (head_i.op == OP_MOD);
  assign div_ovf   = sg && (head_i.op == OP_DIV) && (a == MinV) && (&b);
  assign needs_div = head_valid_i && (head_i.st == ST_OK) && is_div && (b != '0) && !div_ovf;

  cia_div #(
    .DataWidth(DataWidth)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (needs_div && div_idle),
    .dividend_i (mag_a),
    .divisor_i  (mag_b),
    .ack_i      (pop_o),
    .idle_o     (div_idle),
    .done_o     (div_done),
    .quo_o      (quo),
    .rem_o      (rem)
  );

  always_comb begin
    a_st   = head_i.st;
    a_val  = '0;
    a_vsg  = sg;
    a_mul  = 1'b0;
    a_neg  = neg_a ^ neg_b;
    a_pp00 = mag_a[H-1:0] * mag_b[H-1:0];
    a_pp01 = mag_a[H-1:0] * H'(mag_b >> H);
    a_pp10 = H'(mag_a >> H) * mag_b[H-1:0];
    a_pp11 = H'(mag_a >> H) * H'(mag_b >> H);
    if (head_i.st == ST_OK) begin
      unique case (head_i.op)
        OP_OR:  a_val = a | b;
        OP_XOR: a_val = a ^ b;
        OP_AND: a_val = a & b;
        OP_ADD: begin
          a_val = sum[W-1:0];
          if (sg ? (a[W-1] == b[W-1]) && (sum[W-1] != a[W-1]) : sum[W]) begin
            a_st = ST_OVF;
          end
        end
        OP_SUB: begin
          a_val = diff[W-1:0];
          if (sg ? (a[W-1] != b[W-1]) && (diff[W-1] != a[W-1]) : diff[W]) begin
            a_st = ST_OVF;
          end
        end
        OP_MUL: a_mul = 1'b1;
        OP_DIV, OP_MOD: begin
          priority if (b == '0) begin
            a_st = ST_DIV0;
          end else if (div_ovf) begin
            a_st = ST_OVF;
          end else if (head_i.op == OP_DIV) begin
            a_val = a_neg ? {W{1'b0}} - quo : quo;
          end else begin
            a_val = neg_a ? {W{1'b0}} - rem : rem;
          end
        end
        OP_SHR, OP_SHL: begin
          priority if (b > WidthV) begin
            a_st = ST_SHIFT;
          end else if (b == WidthV) begin
            a_val = (head_i.op == OP_SHR && neg_a) ? {W{1'b1}} : {W{1'b0}};
          end else if (head_i.op == OP_SHL) begin
            a_val = a << sh;
          end else if (sg) begin
            a_val = W'($signed(a) >>> sh);
          end else begin
            a_val = a >> sh;
          end
        end
        OP_NEG: begin
          a_vsg = 1'b1;
          if (sg ? (a == MinV) : a[W-1]) begin
            a_st = ST_OVF;
          end else begin
            a_val = {W{1'b0}} - a;
          end
        end
        OP_PLUS: a_val = a;
        OP_NOT:  a_val = ~a;
        default: a_st = ST_INVALID;
      endcase
    end
  end

  // Handshake between the stages.
  assign out_free = !out_valid_q || out_o.ready;
  assign s2_free  = !s2_valid_q || out_free;
  assign a_valid  = head_valid_i && (!needs_div || div_done);
  assign pop_o    = a_valid && s2_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s2_free) begin
        s2_valid_q <= a_valid;
      end
      if (out_free) begin
        out_valid_q <= s2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s2_st_q   <= a_st;
      s2_val_q  <= a_val;
      s2_vsg_q  <= a_vsg;
      s2_mul_q  <= a_mul;
      s2_neg_q  <= a_neg;
      s2_pp00_q <= a_pp00;
      s2_pp01_q <= a_pp01;
      s2_pp10_q <= a_pp10;
      s2_pp11_q <= a_pp11;
    end
  end

  // Multiply combine: sum the partial products and range-check the magnitude.
  always_comb begin
    prod = (PW'(s2_pp11_q) << (2 * H))
         + ((PW'(s2_pp01_q) + PW'(s2_pp10_q)) << H)
         + PW'(s2_pp00_q);
    prod_lo    = prod[W-1:0];
    prod_hi_nz = |(prod >> W);
    if (s2_vsg_q) begin
      mul_ovf = prod_hi_nz || (prod_lo > (s2_neg_q ? MinV : MaxP));
    end else begin
      mul_ovf = prod_hi_nz;
    end
    c_st  = s2_st_q;
    c_val = s2_val_q;
    if (s2_mul_q) begin
      c_val = s2_neg_q ? {W{1'b0}} - prod_lo : prod_lo;
      if (mul_ovf) begin
        c_st = ST_OVF;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && s2_valid_q) begin
      out_st_q  <= c_st;
      out_val_q <= (c_st == ST_OK) ? c_val : '0;
      out_vsg_q <= (c_st == ST_OK) && s2_vsg_q;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.value           = MaxWidth'(out_val_q);
  assign out_o.value_is_signed = out_vsg_q;
  assign out_o.status          = out_st_q;

endmodule

// ===== hw/rtl/checked_int64_alu.sv =====
// Top level of the overflow-checked integer ALU.
// This block evaluates one integer operation per transaction on DataWidth-bit
// operands (64 by default) and returns the value, its signedness and a status
// that reports overflow, a zero divisor, an oversized shift, an unknown
// operation or a missing operand; the value is zero whenever the status is not
// ok. Requests enter a front end that classifies them and are held in a
// FifoDepth-entry queue, so the request side keeps moving while the back end
// or the consumer stalls, until the queue is full. Every operation except
// divide and modulo issues at one transaction per cycle while the result side
// is not stalled. Divide and modulo with a usable divisor go through a
// restoring divider that produces one quotient bit per cycle and holds the
// back end until it is done, so no later transaction issues meanwhile.
// Results always come out in request order.
module checked_int64_alu #(
  parameter int unsigned DataWidth = cia_pkg::DataWidthDefault,
  parameter int unsigned FifoDepth = cia_pkg::FifoDepthDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cia_in_if.sink    in_i,
  cia_out_if.source out_o
);
  import cia_pkg::*;

  cmd_t push_cmd, head_cmd;
  logic push, full, pop, head_valid;

  cia_front #(
    .DataWidth(DataWidth)
  ) u_front (
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .cmd_o  (push_cmd)
  );

  cia_fifo #(
    .Depth(FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .data_o  (head_cmd)
  );

  cia_back #(
    .DataWidth(DataWidth)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head_cmd),
    .pop_o        (pop),
    .out_o        (out_o)
  );

endmodule

// ===== hw/rtl/cia_checker.sv =====
// Port-level assertions for the checked integer ALU and their binding.
module cia_checker #(
  parameter int unsigned DataWidth = cia_pkg::DataWidthDefault
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [63:0] value_i,
  input logic        value_is_signed_i,
  input logic [2:0]  status_i
);
  import cia_pkg::*;

  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("result valid during reset");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(value_i)
      && $stable(status_i) && $stable(value_is_signed_i))
    else $error("stalled result changed");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i != ST_OK) |-> (value_i == '0) && !value_is_signed_i)
    else $error("error result carries a value");

  a_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ((value_i >> DataWidth) == '0))
    else $error("result exceeds data width");

endmodule

bind checked_int64_alu cia_checker #(
  .DataWidth(DataWidth)
) u_cia_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .value_i           (out_o.value),
  .value_is_signed_i (out_o.value_is_signed),
  .status_i          (out_o.status)
);

// ===== tb/sv/checked_int64_alu_checker.sv =====
// Result checker for the checked integer ALU: predicts each result and compares it.
module checked_int64_alu_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  cia_in_if.monitor   req_mon,
  cia_out_if.monitor  rsp_mon,
  output int unsigned mismatches_o,
  output int unsigned pending_o,
  output logic        accepted_o
);
  import cia_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [63:0] value;
    logic        vsg;
    status_e     st;
  } alu_result_t;

  localparam logic [63:0] SignBit = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MaxPos  = 64'h7FFF_FFFF_FFFF_FFFF;

  alu_result_t expected_q[$];

  function automatic logic [63:0] magnitude(logic [63:0] x);
    return x[63] ? -x : x;
  endfunction

  function automatic alu_result_t predict_alu(logic [3:0] kind, logic sg, logic present,
                                              logic [63:0] a, logic [63:0] b);
    alu_result_t res;
    logic [127:0] prod;
    logic [64:0]  wide;
    logic [63:0]  r;
    logic         neg;
    res = '{value: '0, vsg: sg, st: ST_OK};
    r = '0;
    if (!present) res.st = ST_NOVALUE;
    else if (kind > OP_NOT) res.st = ST_INVALID;
    else begin
      case (op_e'(kind))
        OP_OR:  r = a | b;
        OP_XOR: r = a ^ b;
        OP_AND: r = a & b;
        OP_ADD: begin
          r = a + b;
          wide = {1'b0, a} + {1'b0, b};
          if (sg ? (a[63] == b[63] && r[63] != a[63]) : wide[64]) res.st = ST_OVF;
        end
        OP_SUB: begin
          r = a - b;
          if (sg ? (a[63] != b[63] && r[63] != a[63]) : (b > a)) res.st = ST_OVF;
        end
        OP_MUL: begin
          if (sg) begin
            neg = a[63] ^ b[63];
            prod = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
            if (prod[127:64] != 0 || prod[63:0] > (neg ? SignBit : MaxPos)) res.st = ST_OVF;
            r = neg ? -prod[63:0] : prod[63:0];
          end else begin
            prod = {64'd0, a} * {64'd0, b};
            if (prod[127:64] != 0) res.st = ST_OVF;
            r = prod[63:0];
          end
        end
        OP_DIV, OP_MOD: begin
          if (b == 0) res.st = ST_DIV0;
          else if (!sg) r = (kind == OP_DIV) ? a / b : a % b;
          else if (kind == OP_DIV) begin
            if (a == SignBit && b == '1) res.st = ST_OVF;
            r = magnitude(a) / magnitude(b);
            if (a[63] != b[63]) r = -r;
          end else begin
            r = magnitude(a) % magnitude(b);
            if (a[63]) r = -r;
          end
        end
        OP_SHR, OP_SHL: begin
          if (b > 64) res.st = ST_SHIFT;
          else if (b == 64) r = (kind == OP_SHR && sg && a[63]) ? '1 : '0;
          else if (kind == OP_SHL) r = a << b[6:0];
          else if (sg) r = $signed(a) >>> b[6:0];
          else r = a >> b[6:0];
        end
        OP_NEG: begin
          if (sg ? (a == SignBit) : (a > MaxPos)) res.st = ST_OVF;
          r = -a;
          res.vsg = 1'b1;
        end
        OP_PLUS: r = a;
        default: r = ~a;
      endcase
    end
    if (res.st != ST_OK) begin
      res.value = '0;
      res.vsg   = 1'b0;
    end else res.value = r;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    alu_result_t want;
    if (!rst_ni) begin
      expected_q.delete();
      mismatches_o <= 0;
      accepted_o   <= 1'b0;
    end else begin
      accepted_o <= (req_mon.valid && req_mon.ready) || (rsp_mon.valid && rsp_mon.ready);
      if (req_mon.valid && req_mon.ready)
        expected_q.push_back(predict_alu(req_mon.kind, req_mon.sign_mode,
                             req_mon.operands_present, req_mon.left_operand,
                             req_mon.right_operand));
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (expected_q.size() == 0) begin
          if (mismatches_o < 10) $display("unexpected result value=%h", rsp_mon.value);
          mismatches_o <= mismatches_o + 1;
        end else begin
          want = expected_q.pop_front();
          if (rsp_mon.value !== want.value || rsp_mon.value_is_signed !== want.vsg ||
              rsp_mon.status !== want.st) begin
            if (mismatches_o < 10)
              $display("mismatch: expected %h/%b/%0d got %h/%b/%0d", want.value, want.vsg,
                       want.st, rsp_mon.value, rsp_mon.value_is_signed, rsp_mon.status);
            mismatches_o <= mismatches_o + 1;
          end
        end
      end
    end
  end

  assign pending_o = expected_q.size();
endmodule

// ===== tb/sv/checked_int64_alu_tb.sv =====
// Testbench top of the checked integer ALU: stimulus, flow control and verdict.
module checked_int64_alu_tb;
  import cia_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WatchdogLimit = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b1;
  int unsigned mismatches;
  int unsigned pending;
  logic        accepted;
  int unsigned idle_cycles;
  // Percent chance per cycle that the sender idles or the receiver stalls.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  // While set, the receiver holds ready low regardless of the stall chance.
  logic        hold_off = 1'b0;

  cia_in_if  req_if ();
  cia_out_if rsp_if ();

  checked_int64_alu dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_if.sink),
    .out_o (rsp_if.source)
  );

  checked_int64_alu_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_mon     (req_if.monitor),
    .rsp_mon     (rsp_if.monitor),
    .mismatches_o(mismatches),
    .pending_o   (pending),
    .accepted_o  (accepted)
  );

  always #1 clk_i = ~clk_i;

  initial begin
    req_if.valid = 1'b0;
    req_if.kind = '0;
    req_if.sign_mode = 1'b0;
    req_if.operands_present = 1'b0;
    req_if.left_operand = '0;
    req_if.right_operand = '0;
    rsp_if.ready = 1'b0;
  end

  // The receiver stalls at random, or holds off fully while a long stall is in force.
  always @(posedge clk_i) begin
    if (rst_ni)
      rsp_if.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  // Operand generator that favors the corner values of the 64-bit range.
  function automatic logic [63:0] pick_operand();
    case ($urandom_range(9))
      0: return 64'd0;
      1: return 64'd1;
      2: return '1;
      3: return 64'h8000_0000_0000_0000;
      4: return 64'h7FFF_FFFF_FFFF_FFFF;
      5: return 64'($urandom_range(70));
      6: return {32'd0, $urandom()};
      7: return {{32{1'b1}}, $urandom()};
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // Offers one transaction and waits until it is accepted; the sender may idle first.
  task automatic send_request(logic [3:0] kind, logic sg, logic present,
                              logic [63:0] a, logic [63:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.kind <= kind;
    req_if.sign_mode <= sg;
    req_if.operands_present <= present;
    req_if.left_operand <= a;
    req_if.right_operand <= b;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  task automatic send_random(int unsigned count);
    logic [3:0] kind;
    for (int unsigned i = 0; i < count; i++) begin
      kind = ($urandom_range(19) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(12));
      send_request(kind, 1'($urandom), $urandom_range(29) != 0,
                   pick_operand(), pick_operand());
    end
  endtask

  // Drops valid, lets the last accepted transaction count as pending, then waits until none is.
  task automatic drain();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Ends the run if no transaction moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || accepted) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    rst_ni <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: cases of every operation but AND and XOR, an unknown operation and a missing operand.
    send_request(OP_ADD, 1'b0, 1'b1, '1, 64'd1);
    send_request(OP_ADD, 1'b1, 1'b1, 64'h7FFF_FFFF_FFFF_FFFF, 64'd1);
    send_request(OP_SUB, 1'b0, 1'b1, 64'd0, 64'd1);
    send_request(OP_SUB, 1'b1, 1'b1, 64'h8000_0000_0000_0000, 64'd1);
    send_request(OP_MUL, 1'b1, 1'b1, 64'h8000_0000_0000_0000, '1);
    send_request(OP_MUL, 1'b1, 1'b1, 64'h4000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFE);
    send_request(OP_MUL, 1'b0, 1'b1, '1, '1);
    send_request(OP_DIV, 1'b0, 1'b1, 64'd7, 64'd0);
    send_request(OP_MOD, 1'b1, 1'b1, 64'd7, 64'd0);
    send_request(OP_DIV, 1'b1, 1'b1, 64'h8000_0000_0000_0000, '1);
    send_request(OP_MOD, 1'b1, 1'b1, 64'h8000_0000_0000_0000, '1);
    send_request(OP_DIV, 1'b1, 1'b1, -64'sd7, 64'd2);
    send_request(OP_MOD, 1'b1, 1'b1, -64'sd7, 64'd2);
    send_request(OP_SHR, 1'b1, 1'b1, 64'h8000_0000_0000_0000, 64'd64);
    send_request(OP_SHR, 1'b1, 1'b1, 64'h8000_0000_0000_0000, 64'd63);
    send_request(OP_SHL, 1'b0, 1'b1, '1, 64'd65);
    send_request(OP_SHL, 1'b1, 1'b1, '1, '1);
    send_request(OP_NEG, 1'b1, 1'b1, 64'h8000_0000_0000_0000, '0);
    send_request(OP_NEG, 1'b0, 1'b1, 64'h8000_0000_0000_0000, '0);
    send_request(OP_NEG, 1'b0, 1'b1, 64'd5, '0);
    send_request(OP_PLUS, 1'b1, 1'b1, '1, '1);
    send_request(OP_NOT, 1'b0, 1'b1, '0, '0);
    send_request(OP_OR, 1'b0, 1'b1, 64'hF0F0, 64'h0F0F);
    send_request(4'd15, 1'b1, 1'b1, '1, '1);
    send_request(OP_XOR, 1'b1, 1'b0, '1, '1);

    // Random phases with different idling on either side.
    send_random(180);
    send_idle_pct = 81;
    send_random(130);
    send_idle_pct = 0;
    recv_stall_pct = 81;
    send_random(130);
    send_idle_pct = 36;
    recv_stall_pct = 36;
    send_random(130);

    // Sender pauses until every expected result has come.
    drain();
    send_idle_pct = 0;
    recv_stall_pct = 0;

    // The receiver holds off for a long stretch while the sender keeps offering.
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(posedge clk_i);
        hold_off = 1'b0;
      end
      send_random(60);
    join
    send_random(120);

    drain();
    repeat (150) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
